// File: src/assert_macros.svh
// Shared assertion macros. Every macro samples on the rising edge of clk and
// is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: src/bmftl_pkg.sv
package bmftl_pkg;

  localparam int ACT_W  = 2;
  localparam int SEC_W  = 12;
  localparam int SCAN_W = 9;
  localparam int CMD_W  = 3;
  localparam int PG_W   = 13;
  localparam int OWN_W  = 8;

  localparam int SEC_MAX = 4095;
  localparam logic [SCAN_W-1:0] OWNER_ERASED = 9'h1FF;

  typedef enum logic [ACT_W-1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_SCAN  = 2'd2
  } act_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_PROGRAM  = 3'd0,
    CMD_COPY     = 3'd1,
    CMD_ERASE    = 3'd2,
    CMD_READ     = 3'd3,
    CMD_UNMAPPED = 3'd4,
    CMD_SCAN_OK  = 3'd5
  } cmd_e;

  // Microprogram step addresses.
  typedef enum logic [3:0] {
    S_CLEAR  = 4'd0,
    S_IDLE   = 4'd1,
    S_DIV    = 4'd2,
    S_FIX    = 4'd3,
    S_LOOK   = 4'd4,
    S_DISP   = 4'd5,
    S_READ   = 4'd6,
    S_UNMAP  = 4'd7,
    S_FIRST  = 4'd8,
    S_FMARK  = 4'd9,
    S_FDATA  = 4'd10,
    S_ULOOP  = 4'd11,
    S_UERASE = 4'd12,
    S_SSPARE = 4'd13,
    S_SMAP   = 4'd14
  } step_e;

  typedef enum logic [2:0] {
    DP_NONE, DP_CLR, DP_LOAD, DP_MUL, DP_FIX, DP_BASE, DP_PINC
  } dp_e;

  typedef enum logic [2:0] {
    PG_NONE, PG_READ, PG_MARK, PG_SECTOR, PG_LOOP, PG_ERASE
  } pg_e;

  typedef enum logic [1:0] {ADDR_LBN, ADDR_OWNER, ADDR_CLR} addr_e;
  typedef enum logic [1:0] {WD_CLEAR, WD_LBN, WD_SPARE, WD_SBLOCK} wd_e;
  typedef enum logic {SP_OLD, SP_SBLOCK} sp_e;
  typedef enum logic [1:0] {BR_NEXT, BR_JUMP, BR_IF, BR_DISP} br_e;
  typedef enum logic [1:0] {CC_CLR_MORE, CC_OFF_ZERO, CC_PAGE_MORE} cc_e;

  typedef struct packed {
    logic  wait_in;
    logic  emit;
    cmd_e  cmd;
    pg_e   pg;
    logic  has_sec;
    logic  last;
    logic  map_we;
    addr_e addr;
    wd_e   wd;
    logic  spare_we;
    sp_e   sp;
    dp_e   dp;
    br_e   br;
    cc_e   cc;
    step_e target;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic fire;
  } ctl_t;

  typedef struct packed {
    logic  clr_more;
    logic  off_zero;
    logic  page_more;
    logic  slot_free;
    step_e disp;
  } stat_t;

  function automatic uop_t ucode_rom(step_e s);
    uop_t u;
    u = '0;
    u.cmd    = CMD_PROGRAM;
    u.br     = BR_NEXT;
    u.target = S_IDLE;
    case (s)
      S_CLEAR: begin
        u.dp     = DP_CLR;
        u.map_we = 1'b1;
        u.addr   = ADDR_CLR;
        u.wd     = WD_CLEAR;
        u.br     = BR_IF;
        u.cc     = CC_CLR_MORE;
        u.target = S_CLEAR;
      end
      S_IDLE: begin
        u.wait_in = 1'b1;
        u.dp      = DP_LOAD;
      end
      S_DIV:  u.dp = DP_MUL;
      S_FIX:  u.dp = DP_FIX;
      S_LOOK: u.dp = DP_NONE;
      S_DISP: begin
        u.dp = DP_BASE;
        u.br = BR_DISP;
      end
      S_READ: begin
        u.emit = 1'b1;
        u.cmd  = CMD_READ;
        u.pg   = PG_READ;
        u.last = 1'b1;
        u.br   = BR_JUMP;
      end
      S_UNMAP: begin
        u.emit = 1'b1;
        u.cmd  = CMD_UNMAPPED;
        u.last = 1'b1;
        u.br   = BR_JUMP;
      end
      S_FIRST: begin
        u.map_we = 1'b1;
        u.addr   = ADDR_LBN;
        u.wd     = WD_LBN;
        u.br     = BR_IF;
        u.cc     = CC_OFF_ZERO;
        u.target = S_FDATA;
      end
      S_FMARK: begin
        u.emit = 1'b1;
        u.pg   = PG_MARK;
      end
      S_FDATA: begin
        u.emit    = 1'b1;
        u.pg      = PG_SECTOR;
        u.has_sec = 1'b1;
        u.last    = 1'b1;
        u.br      = BR_JUMP;
      end
      S_ULOOP: begin
        u.emit   = 1'b1;
        u.pg     = PG_LOOP;
        u.dp     = DP_PINC;
        u.br     = BR_IF;
        u.cc     = CC_PAGE_MORE;
        u.target = S_ULOOP;
      end
      S_UERASE: begin
        u.emit     = 1'b1;
        u.cmd      = CMD_ERASE;
        u.pg       = PG_ERASE;
        u.last     = 1'b1;
        u.map_we   = 1'b1;
        u.addr     = ADDR_LBN;
        u.wd       = WD_SPARE;
        u.spare_we = 1'b1;
        u.sp       = SP_OLD;
        u.br       = BR_JUMP;
      end
      S_SSPARE: begin
        u.emit     = 1'b1;
        u.cmd      = CMD_SCAN_OK;
        u.last     = 1'b1;
        u.spare_we = 1'b1;
        u.sp       = SP_SBLOCK;
        u.br       = BR_JUMP;
      end
      S_SMAP: begin
        u.emit   = 1'b1;
        u.cmd    = CMD_SCAN_OK;
        u.last   = 1'b1;
        u.map_we = 1'b1;
        u.addr   = ADDR_OWNER;
        u.wd     = WD_SBLOCK;
        u.br     = BR_JUMP;
      end
      default: begin
        u.br = BR_JUMP;
      end
    endcase
    return u;
  endfunction

endpackage

// File: src/bmftl_ram.sv
module bmftl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/bmftl_seq.sv
`include "assert_macros.svh"

module bmftl_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bmftl_pkg::stat_t stat,
  output bmftl_pkg::ctl_t  ctl
);
  import bmftl_pkg::*;

  step_e pc_r, pc_nxt;
  uop_t  uop;
  logic  fire;
  logic  cond;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_CLEAR;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // Output decode: fetch the control word and decide whether this step runs.
  always_comb begin
    uop      = ucode_rom(pc_r);
    in_ready = uop.wait_in;
    if (uop.wait_in) begin
      fire = in_valid;
    end else begin
      fire = !uop.emit || stat.slot_free;
    end
    ctl.uop  = uop;
    ctl.fire = fire;
  end

  always_comb begin
    case (uop.cc)
      CC_CLR_MORE:  cond = stat.clr_more;
      CC_OFF_ZERO:  cond = stat.off_zero;
      CC_PAGE_MORE: cond = stat.page_more;
      default:      cond = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    if (fire) begin
      case (uop.br)
        BR_NEXT: pc_nxt = step_e'(pc_r + 4'd1);
        BR_JUMP: pc_nxt = uop.target;
        BR_IF:   pc_nxt = cond ? uop.target : step_e'(pc_r + 4'd1);
        BR_DISP: pc_nxt = stat.disp;
        default: pc_nxt = S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_stall_holds_step, uop.emit && !uop.wait_in && !stat.slot_free, $stable(pc_r), "step advanced while its command was blocked")
  `ASSERT_NEXT(a_idle_waits, pc_r == S_IDLE && !in_valid, pc_r == S_IDLE, "sequencer left idle without an input beat")

endmodule

// File: src/bmftl_dpath.sv
`include "assert_macros.svh"

module bmftl_dpath #(
  parameter int PAGES_IN_BLOCK = 16,
  parameter int DATA_BLOCKS    = 256
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  bmftl_pkg::ctl_t                         ctl,
  output bmftl_pkg::stat_t                        stat,
  input  logic [bmftl_pkg::ACT_W-1:0]             in_action,
  input  logic [bmftl_pkg::SEC_W-1:0]             in_sector_number,
  input  logic [bmftl_pkg::SCAN_W-1:0]            in_scan_block,
  input  logic signed [bmftl_pkg::SCAN_W-1:0]     in_scan_owner,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [bmftl_pkg::CMD_W-1:0]             out_command,
  output logic [bmftl_pkg::PG_W-1:0]              out_page_address,
  output logic [bmftl_pkg::PG_W-1:0]              out_source_page,
  output logic [bmftl_pkg::OWN_W-1:0]             out_spare_owner,
  output logic                                    out_spare_has_sector,
  output logic [bmftl_pkg::SEC_W-1:0]             out_spare_sector,
  output logic                                    out_last
);
  import bmftl_pkg::*;

  localparam int OFF_W  = $clog2(PAGES_IN_BLOCK);
  localparam int LBN_W  = $clog2(SEC_MAX / PAGES_IN_BLOCK + 1);
  localparam int PBW    = $clog2(DATA_BLOCKS + 1);
  localparam int AW     = $clog2(DATA_BLOCKS);
  localparam int EW     = PBW + 1;
  // Quotient by reciprocal: the estimate is at most one below the true value.
  localparam int DIV_SH = 24;
  localparam int DIV_M  = (1 << DIV_SH) / PAGES_IN_BLOCK;
  localparam int PROD_W = SEC_W + DIV_SH;

  uop_t u;
  logic step_go;

  act_e              action_r;
  logic [SEC_W-1:0]  sector_r;
  logic [SCAN_W-1:0] sblock_r;
  logic [SCAN_W-1:0] owner_r;
  logic [PROD_W-1:0] prod_r;
  logic [LBN_W-1:0]  lbn_r;
  logic [OFF_W-1:0]  off_r;
  logic [OFF_W-1:0]  page_r;
  logic [PBW-1:0]    old_r;
  logic [PG_W-1:0]   old_base_r;
  logic [PG_W-1:0]   fresh_base_r;
  logic [PBW-1:0]    spare_r;
  logic [AW-1:0]     clr_r;

  logic [SEC_W-1:0]  fix_q;
  logic [SEC_W-1:0]  fix_rem;

  logic [AW-1:0]     map_addr;
  logic [EW-1:0]     map_wdata;
  logic [EW-1:0]     map_rdata;
  logic              map_we;
  logic              rd_valid;
  logic [PBW-1:0]    rd_blk;
  logic              lbn_ok;

  logic              out_valid_r;
  cmd_e              out_cmd_r;
  logic [PG_W-1:0]   out_page_r;
  logic [PG_W-1:0]   out_src_r;
  logic [OWN_W-1:0]  out_owner_r;
  logic              out_has_r;
  logic [SEC_W-1:0]  out_sec_r;
  logic              out_last_r;

  cmd_e              o_cmd;
  logic [PG_W-1:0]   o_page;
  logic [PG_W-1:0]   o_src;
  logic [OWN_W-1:0]  o_owner;
  logic              o_has;
  logic [SEC_W-1:0]  o_sec;
  logic              hit;
  step_e             disp;

  assign u       = ctl.uop;
  assign step_go = ctl.fire;

  always_comb begin
    fix_q   = SEC_W'(prod_r >> DIV_SH);
    fix_rem = sector_r - SEC_W'(fix_q * PAGES_IN_BLOCK);
  end

  always_comb begin
    case (u.addr)
      ADDR_LBN:   map_addr = AW'(lbn_r);
      ADDR_OWNER: map_addr = AW'(owner_r);
      ADDR_CLR:   map_addr = clr_r;
      default:    map_addr = AW'(lbn_r);
    endcase
    case (u.wd)
      WD_CLEAR:  map_wdata = '0;
      WD_LBN:    map_wdata = {1'b1, PBW'(lbn_r)};
      WD_SPARE:  map_wdata = {1'b1, spare_r};
      WD_SBLOCK: map_wdata = {1'b1, PBW'(sblock_r)};
      default:   map_wdata = '0;
    endcase
    map_we = step_go && u.map_we;
  end

  bmftl_ram #(
    .WIDTH (EW),
    .DEPTH (DATA_BLOCKS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .addr  (map_addr),
    .wdata (map_wdata),
    .rdata (map_rdata)
  );

  assign rd_valid = map_rdata[PBW];
  assign rd_blk   = map_rdata[PBW-1:0];
  assign lbn_ok   = int'(lbn_r) < DATA_BLOCKS;

  // Pick the routine for the item once the map entry has been read.
  always_comb begin
    case (action_r)
      ACT_READ: begin
        disp = (lbn_ok && rd_valid) ? S_READ : S_UNMAP;
      end
      ACT_WRITE: begin
        if (!lbn_ok) begin
          disp = S_IDLE;
        end else if (!rd_valid) begin
          disp = S_FIRST;
        end else begin
          disp = S_ULOOP;
        end
      end
      ACT_SCAN: begin
        if (int'(sblock_r) > DATA_BLOCKS) begin
          disp = S_IDLE;
        end else if (owner_r == OWNER_ERASED) begin
          disp = S_SSPARE;
        end else if (!owner_r[SCAN_W-1] && int'(owner_r) < DATA_BLOCKS) begin
          disp = S_SMAP;
        end else begin
          disp = S_IDLE;
        end
      end
      default: disp = S_IDLE;
    endcase
  end

  always_comb begin
    stat.clr_more  = clr_r != AW'(DATA_BLOCKS - 1);
    stat.off_zero  = off_r == '0;
    stat.page_more = page_r != OFF_W'(PAGES_IN_BLOCK - 1);
    stat.slot_free = !out_valid_r || out_ready;
    stat.disp      = disp;
  end

  // Command fields for the current step. Inside the update loop the written
  // offset becomes a data program and every other page a copy.
  always_comb begin
    hit    = page_r == off_r;
    o_cmd  = u.cmd;
    o_page = '0;
    o_src  = '0;
    o_has  = u.has_sec;
    case (u.pg)
      PG_READ:   o_page = old_base_r + PG_W'(off_r);
      PG_MARK:   o_page = PG_W'(sector_r - SEC_W'(off_r));
      PG_SECTOR: o_page = PG_W'(sector_r);
      PG_LOOP: begin
        o_page = fresh_base_r + PG_W'(page_r);
        o_has  = hit;
        if (!hit) begin
          o_cmd = CMD_COPY;
          o_src = old_base_r + PG_W'(page_r);
        end
      end
      PG_ERASE:  o_page = PG_W'(old_r);
      default:   o_page = '0;
    endcase
    o_owner = (o_cmd == CMD_PROGRAM) ? OWN_W'(lbn_r) : '0;
    o_sec   = o_has ? sector_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      spare_r     <= PBW'(DATA_BLOCKS);
      clr_r       <= '0;
    end else begin
      if (step_go && u.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (step_go && u.spare_we) begin
        spare_r <= (u.sp == SP_OLD) ? old_r : PBW'(sblock_r);
      end
      if (step_go && u.dp == DP_CLR) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      case (u.dp)
        DP_LOAD: begin
          action_r <= act_e'(in_action);
          sector_r <= in_sector_number;
          sblock_r <= in_scan_block;
          owner_r  <= in_scan_owner;
        end
        DP_MUL: prod_r <= PROD_W'(sector_r) * PROD_W'(DIV_M);
        DP_FIX: begin
          if (int'(fix_rem) >= PAGES_IN_BLOCK) begin
            lbn_r <= LBN_W'(fix_q + 1'b1);
            off_r <= OFF_W'(fix_rem - SEC_W'(PAGES_IN_BLOCK));
          end else begin
            lbn_r <= LBN_W'(fix_q);
            off_r <= OFF_W'(fix_rem);
          end
        end
        DP_BASE: begin
          old_r        <= rd_blk;
          old_base_r   <= PG_W'(rd_blk * PAGES_IN_BLOCK);
          fresh_base_r <= PG_W'(spare_r * PAGES_IN_BLOCK);
          page_r       <= '0;
        end
        DP_PINC: page_r <= page_r + 1'b1;
        default: begin
        end
      endcase
      if (u.emit) begin
        out_cmd_r   <= o_cmd;
        out_page_r  <= o_page;
        out_src_r   <= o_src;
        out_owner_r <= o_owner;
        out_has_r   <= o_has;
        out_sec_r   <= o_sec;
        out_last_r  <= u.last;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_command          = out_cmd_r;
  assign out_page_address     = out_page_r;
  assign out_source_page      = out_src_r;
  assign out_spare_owner      = out_owner_r;
  assign out_spare_has_sector = out_has_r;
  assign out_spare_sector     = out_sec_r;
  assign out_last             = out_last_r;

  `ASSERT_CLK(a_erase_after_loop, ctl.fire && ctl.uop.pg == PG_ERASE |-> page_r == OFF_W'(PAGES_IN_BLOCK), "erase issued before every page of the block was handled")
  `ASSERT_CLK(a_spare_range, int'(spare_r) <= DATA_BLOCKS, "spare block number out of range")

endmodule

// File: src/block_mapping_ftl_top.sv
// Channel   Direction  Handshake             Beat contents
// in        input      in_valid / in_ready   action, sector_number, scan_block, scan_owner
// out       output     out_valid / out_ready command, addresses, spare tags, last
//
// Every record runs the accept, divide, fix, lookup and dispatch steps; then a read
// or a scan issues one command, a first write does a map write, an optional marker
// and the data program, and an update moves the block to the spare, one page
// command per cycle unless the output stalls, then erases the old block. After reset
// the sequencer sweeps the map RAM, one entry a cycle, with in_ready low until done.
// A beat waiting in the output register stalls only a step that issues a command.
module block_mapping_ftl_top #(
  parameter int PAGES_IN_BLOCK = 16,
  parameter int DATA_BLOCKS    = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bmftl_pkg::ACT_W-1:0]         in_action,
  input  logic [bmftl_pkg::SEC_W-1:0]         in_sector_number,
  input  logic [bmftl_pkg::SCAN_W-1:0]        in_scan_block,
  input  logic signed [bmftl_pkg::SCAN_W-1:0] in_scan_owner,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bmftl_pkg::CMD_W-1:0]         out_command,
  output logic [bmftl_pkg::PG_W-1:0]          out_page_address,
  output logic [bmftl_pkg::PG_W-1:0]          out_source_page,
  output logic [bmftl_pkg::OWN_W-1:0]         out_spare_owner,
  output logic                                out_spare_has_sector,
  output logic [bmftl_pkg::SEC_W-1:0]         out_spare_sector,
  output logic                                out_last
);
  import bmftl_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  bmftl_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  bmftl_dpath #(
    .PAGES_IN_BLOCK (PAGES_IN_BLOCK),
    .DATA_BLOCKS    (DATA_BLOCKS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ctl                  (ctl),
    .stat                 (stat),
    .in_action            (in_action),
    .in_sector_number     (in_sector_number),
    .in_scan_block        (in_scan_block),
    .in_scan_owner        (in_scan_owner),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_command          (out_command),
    .out_page_address     (out_page_address),
    .out_source_page      (out_source_page),
    .out_spare_owner      (out_spare_owner),
    .out_spare_has_sector (out_spare_has_sector),
    .out_spare_sector     (out_spare_sector),
    .out_last             (out_last)
  );

endmodule
